/* design/wsm_pkg.sv */
// Shared types and codes for the watchpoint slot manager.
// No dependencies; imported by wsm_cell, wsm_list and watchpoint_slot_manager.
package wsm_pkg;

  // Request codes
  typedef enum logic [2:0] {
    REQ_REINIT  = 3'd0,
    REQ_ALLOC   = 3'd1,
    REQ_FREE    = 3'd2,
    REQ_LIST    = 3'd3,
    REQ_COMPARE = 3'd4
  } req_e;

  // Result status codes
  typedef enum logic [2:0] {
    STS_OK           = 3'd0,
    STS_NONE_AVAIL   = 3'd1,
    STS_INVALID      = 3'd2,
    STS_NONE_CREATED = 3'd3,
    STS_NOT_CREATED  = 3'd4
  } status_e;

  // Per-cycle operation broadcast along a list of cells
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INIT   = 2'd1,
    CELL_APPEND = 2'd2,
    CELL_SHIFT  = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     wrap;  // on shift, the last occupied cell (index cnt-1) takes the head entry
  } cell_ctl_t;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned SlotOutW = 5;

endpackage

/* design/wsm_cell.sv */
// One list cell: holds a single slot number and passes it toward the head.
// Depends on wsm_pkg.
module wsm_cell #(
  parameter int unsigned POOL_SIZE = 32,
  parameter int unsigned IDX       = 0
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wsm_pkg::cell_ctl_t               ctl_i,
  input  logic [$clog2(POOL_SIZE+1)-1:0]   cnt_i,
  input  logic [$clog2(POOL_SIZE)-1:0]     din_i,
  input  logic [$clog2(POOL_SIZE)-1:0]     nbr_i,
  input  logic [$clog2(POOL_SIZE)-1:0]     head_i,
  output logic [$clog2(POOL_SIZE)-1:0]     q_o
);
  import wsm_pkg::*;

  localparam int unsigned SlotW = $clog2(POOL_SIZE);
  localparam int unsigned CntW  = $clog2(POOL_SIZE + 1);

  logic [SlotW-1:0] val_d, val_q;

  // next entry
  always_comb begin
    case (ctl_i.op)
      CELL_HOLD:   val_d = val_q;
      CELL_INIT:   val_d = SlotW'(IDX);
      CELL_APPEND: val_d = (cnt_i == CntW'(IDX)) ? din_i : val_q;
      CELL_SHIFT:  val_d = (ctl_i.wrap && (cnt_i == CntW'(IDX + 1))) ? head_i : nbr_i;
      default:     val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= SlotW'(IDX);
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

/* design/wsm_list.sv */
// Ordered list of slot numbers built as a row of wsm_cell, head at cell 0.
// Depends on wsm_pkg and wsm_cell.
module wsm_list #(
  parameter int unsigned POOL_SIZE = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  wsm_pkg::cell_ctl_t               ctl_i,
  input  logic [$clog2(POOL_SIZE+1)-1:0]   cnt_i,
  input  logic [$clog2(POOL_SIZE)-1:0]     din_i,
  output logic [$clog2(POOL_SIZE)-1:0]     head_o
);
  import wsm_pkg::*;

  localparam int unsigned SlotW = $clog2(POOL_SIZE);

  logic [SlotW-1:0] val [POOL_SIZE];

  // chain of cells, each fed by its right neighbor
  for (genvar i = 0; i < POOL_SIZE; i++) begin : g_cell
    logic [SlotW-1:0] nbr;
    if (i == POOL_SIZE - 1) begin : g_tail
      assign nbr = val[i];
    end else begin : g_mid
      assign nbr = val[i+1];
    end
    wsm_cell #(
      .POOL_SIZE(POOL_SIZE),
      .IDX      (i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl_i),
      .cnt_i (cnt_i),
      .din_i (din_i),
      .nbr_i (nbr),
      .head_i(val[0]),
      .q_o   (val[i])
    );
  end

  assign head_o = val[0];

endmodule

/* design/watchpoint_slot_manager.sv */
// Watchpoint slot manager: used list and free FIFO as rows of cells, values in a RAM.
// Reinit and allocate: result registered in the cycle after the request is taken.
// Free and compare: walk the used list, visiting each used slot in S_WALK, then finish in S_FIN.
// List: for each used slot, a value RAM read (S_LRD), then emit (S_LEMIT). One request at a time.
// Reset: free list 0..POOL_SIZE-1 ascending, used list empty, all values read as zero
// through per-slot valid bits; no clearing pass. Depends on wsm_pkg, wsm_list.
module watchpoint_slot_manager #(
  parameter int unsigned POOL_SIZE = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [2:0]                    req_type_i,
  input  logic [5:0]                    slot_in_i,
  input  logic [wsm_pkg::ValueW-1:0]    new_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [wsm_pkg::SlotOutW-1:0]  slot_out_o,
  output logic [wsm_pkg::ValueW-1:0]    old_value_o,
  output logic                          changed_o,
  output logic                          last_o
);
  import wsm_pkg::*;

  localparam int unsigned SlotW = $clog2(POOL_SIZE);
  localparam int unsigned CntW  = $clog2(POOL_SIZE + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_FIN,
    S_LRD,
    S_LEMIT
  } state_e;

  state_e            state_q;
  logic [CntW-1:0]   used_cnt_q, free_cnt_q, left_q;
  logic              found_q, is_free_q;
  logic [SlotW-1:0]  slot_q;
  logic [ValueW-1:0] nv_q;

  logic                out_valid_d, out_valid_q, changed_q, last_q;
  logic                out_set;
  logic [2:0]          status_q;
  logic [SlotOutW-1:0] slot_out_q;
  logic [ValueW-1:0]   old_value_q;

  // value RAM with per-slot written flags
  logic [ValueW-1:0]    mem_q [POOL_SIZE];
  logic [POOL_SIZE-1:0] mem_vld_q;
  logic [ValueW-1:0]    rd_data_q;
  logic                 rd_vld_q;
  logic [SlotW-1:0]     rd_addr;
  logic                 mem_we;
  logic [ValueW-1:0]    rv;

  cell_ctl_t        used_ctl, free_ctl;
  logic [SlotW-1:0] used_head, free_head;
  logic             out_free, in_fire, match, slot_bad;

  wsm_list #(.POOL_SIZE(POOL_SIZE)) u_used (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (used_ctl),
    .cnt_i (used_cnt_q),
    .din_i (free_head),
    .head_o(used_head)
  );

  wsm_list #(.POOL_SIZE(POOL_SIZE)) u_free (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (free_ctl),
    .cnt_i (free_cnt_q),
    .din_i (slot_q),
    .head_o(free_head)
  );

  // handshake and list control
  always_comb begin
    out_free      = !out_valid_q || out_ready_i;
    in_ready_o    = (state_q == S_IDLE) && out_free;
    in_fire       = in_valid_i && in_ready_o;
    match         = (used_head == slot_q);
    slot_bad      = {1'b0, slot_in_i} >= 7'(POOL_SIZE);
    rv            = rd_vld_q ? rd_data_q : '0;
    // list keeps reading the head until its result is taken
    rd_addr       = (state_q == S_LRD || state_q == S_LEMIT) ? used_head : slot_q;
    used_ctl.op   = CELL_HOLD;
    used_ctl.wrap = 1'b0;
    free_ctl.op   = CELL_HOLD;
    free_ctl.wrap = 1'b0;
    mem_we        = 1'b0;
    out_set       = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (req_type_i)
            REQ_REINIT: begin
              used_ctl.op = CELL_INIT;
              free_ctl.op = CELL_INIT;
              out_set     = 1'b1;
            end
            REQ_ALLOC: begin
              out_set = 1'b1;
              if (free_cnt_q != '0) begin
                used_ctl.op = CELL_APPEND;
                free_ctl.op = CELL_SHIFT;
              end
            end
            REQ_FREE, REQ_COMPARE: begin
              out_set = slot_bad || (used_cnt_q == '0);
            end
            REQ_LIST: begin
              out_set = (used_cnt_q == '0);
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        // rotate; a freed slot drops out and goes to the free tail
        used_ctl.op   = CELL_SHIFT;
        used_ctl.wrap = !(match && is_free_q);
        if (match && is_free_q) free_ctl.op = CELL_APPEND;
      end
      S_FIN: begin
        mem_we  = out_free && !is_free_q && found_q && (rv != nv_q);
        out_set = out_free;
      end
      S_LEMIT: begin
        if (out_free) begin
          used_ctl.op   = CELL_SHIFT;
          used_ctl.wrap = 1'b1;
          out_set       = 1'b1;
        end
      end
      default: ;
    endcase
    out_valid_d = out_set || (out_valid_q && !out_ready_i);
  end

  // value RAM, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[slot_q] <= nv_q;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (mem_we) mem_vld_q[slot_q] <= 1'b1;
      rd_vld_q <= mem_vld_q[rd_addr];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_cnt_q  <= '0;
      free_cnt_q  <= CntW'(POOL_SIZE);
      left_q      <= '0;
      found_q     <= 1'b0;
      is_free_q   <= 1'b0;
      slot_q      <= '0;
      nv_q        <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STS_OK;
      slot_out_q  <= '0;
      old_value_q <= '0;
      changed_q   <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            slot_q      <= slot_in_i[SlotW-1:0];
            nv_q        <= new_value_i;
            is_free_q   <= (req_type_i == REQ_FREE);
            found_q     <= 1'b0;
            left_q      <= used_cnt_q;
            slot_out_q  <= '0;
            old_value_q <= '0;
            changed_q   <= 1'b0;
            last_q      <= 1'b1;
            case (req_type_i)
              REQ_REINIT: begin
                used_cnt_q  <= '0;
                free_cnt_q  <= CntW'(POOL_SIZE);
                status_q    <= STS_OK;
              end
              REQ_ALLOC: begin
                if (free_cnt_q == '0) begin
                  status_q <= STS_NONE_AVAIL;
                end else begin
                  status_q   <= STS_OK;
                  slot_out_q <= SlotOutW'(free_head);
                  used_cnt_q <= used_cnt_q + 1'b1;
                  free_cnt_q <= free_cnt_q - 1'b1;
                end
              end
              REQ_FREE, REQ_COMPARE: begin
                if (slot_bad) begin
                  status_q    <= STS_INVALID;
                end else if (used_cnt_q == '0) begin
                  status_q    <= STS_NONE_CREATED;
                end else begin
                  state_q <= S_WALK;
                end
              end
              REQ_LIST: begin
                if (used_cnt_q == '0) begin
                  status_q    <= STS_NONE_CREATED;
                end else begin
                  state_q <= S_LRD;
                end
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          found_q <= found_q | match;
          left_q  <= left_q - 1'b1;
          if (match && is_free_q) begin
            used_cnt_q <= used_cnt_q - 1'b1;
            free_cnt_q <= free_cnt_q + 1'b1;
          end
          if (left_q == CntW'(1)) state_q <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state_q     <= S_IDLE;
            if (!found_q) begin
              status_q <= STS_NOT_CREATED;
            end else begin
              status_q   <= STS_OK;
              slot_out_q <= SlotOutW'(slot_q);
              if (!is_free_q) begin
                old_value_q <= rv;
                changed_q   <= (rv != nv_q);
              end
            end
          end
        end
        S_LRD: begin
          state_q <= S_LEMIT;
        end
        S_LEMIT: begin
          if (out_free) begin
            status_q    <= STS_OK;
            slot_out_q  <= SlotOutW'(used_head);
            old_value_q <= rv;
            changed_q   <= 1'b0;
            last_q      <= (left_q == CntW'(1));
            left_q      <= left_q - 1'b1;
            state_q     <= (left_q == CntW'(1)) ? S_IDLE : S_LRD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_out_o  = slot_out_q;
  assign old_value_o = old_value_q;
  assign changed_o   = changed_q;
  assign last_o      = last_q;

endmodule
